/* sv/acsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsm_pkg
// Types and constants of the acceleration consistency spoofing monitor.
// ----------------------------------------------------------------------------
package acsm_pkg;

	localparam int unsigned AccelW = 24;
	localparam int unsigned NumAxes = 6;

	typedef enum logic [2:0] {
		REG_CONVERGENCE_TIME = 3'd0,
		REG_MIN_SATELLITES   = 3'd1,
		REG_DIVERGENCE_LIMIT = 3'd2,
		REG_FORGETTING       = 3'd3,
		REG_WINDOW_RECIP     = 3'd4,
		REG_ALARM_THRESHOLD  = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [23:0] filter_accel_x;
		logic signed [23:0] filter_accel_y;
		logic signed [23:0] filter_accel_z;
		logic signed [23:0] inertial_accel_x;
		logic signed [23:0] inertial_accel_y;
		logic signed [23:0] inertial_accel_z;
		logic [29:0]        week_time_ms;
		logic [29:0]        reset_time_ms;
		logic [6:0]         satellites_used;
	} in_item_t;

	typedef struct packed {
		logic [31:0] normalized_variance;
		logic        alarm;
	} out_item_t;

	typedef logic [NumAxes-1:0][AccelW-1:0] sample_set_t;

endpackage

/* sv/accel_consistency_spoof_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_consistency_spoof_monitor
// Compares averaged filter and inertial acceleration norms and tracks a
// forgetting-factor variance of their difference, with a spoofing alarm.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out, one item at a time. Each input
// passes a sample-memory read, a write, the squaring of the six window sums,
// 32 iterations of the two bit-pair square-root units, the difference, the
// gating checks, the normalizing multiply and the output register; when the
// variance is updated it also passes one squaring and forgetting multiply,
// three reciprocal multiply steps for the division by WINDOW*WINDOW*65536,
// the quotient check and correction, and the update. The input reopens once
// the result is taken. The delay lines sit in one WINDOW-deep sample memory
// whose entries read as zero until written.
module accel_consistency_spoof_monitor #(
	parameter int unsigned WINDOW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  acsm_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output acsm_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import acsm_pkg::*;

	localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SW = AccelW + PW;
	localparam logic [16:0] WSQ = 17'(WINDOW * WINDOW);
	localparam logic [47:0] RECIP = 48'((65'd1 << 48) / 65'(WSQ));

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SUM, S_SQ, S_ROOT, S_DIFF, S_CHK,
		S_MUL, S_REC, S_QD, S_ADJ, S_UPD, S_NRM, S_FIN
	} state_t;

	state_t state_q;

	logic [19:0] conv_q;
	logic [6:0]  minsat_q;
	logic [22:0] limit_q;
	logic [15:0] lambda_q;
	logic [15:0] recip_q;
	logic [31:0] thresh_q;

	sample_set_t mem [WINDOW];
	sample_set_t rd_q;
	sample_set_t wr_data;
	logic [WINDOW-1:0] valid_q;
	logic        rd_valid_q;
	logic [PW-1:0] ptr_q;
	logic        mem_we;

	in_item_t    in_q;
	logic signed [SW-1:0] sum_q [NumAxes];
	logic [63:0] prod_q, acc_f_q, acc_i_q;
	logic [63:0] rad_f_q, rad_i_q;
	logic [33:0] rem_f_q, rem_i_q;
	logic [31:0] root_f_q, root_i_q;
	logic [31:0] d_q;
	logic [63:0] dd_q;
	logic [95:0] rec_q;
	logic [47:0] quot_q, qd_q;
	logic [31:0] lam_q;
	logic [31:0] var_q;
	logic [47:0] nrm_q;
	logic [6:0]  cnt_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic [SW-1:0] mag;
	logic [35:0] trial_f, trial_i, remn_f, remn_i;
	logic [15:0] rec_dig;
	logic [47:0] resid;
	logic signed [30:0] elapsed;
	logic [32:0] lim_w;
	logic [64:0] upd_sum;
	logic [31:0] nrm_v;

	assign wr_data = {in_q.inertial_accel_z, in_q.inertial_accel_y, in_q.inertial_accel_x,
		in_q.filter_accel_z, in_q.filter_accel_y, in_q.filter_accel_x};
	assign mem_we = (state_q == S_SUM);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ptr_q] <= wr_data;
		end
		rd_q <= mem[ptr_q];
	end

	always_comb begin
		mag = '0;
		if (cnt_q < 7'd6) begin
			mag = sum_q[cnt_q[2:0]][SW-1] ? SW'(-sum_q[cnt_q[2:0]])
				: SW'(sum_q[cnt_q[2:0]]);
		end
		remn_f  = {rem_f_q, rad_f_q[63:62]};
		remn_i  = {rem_i_q, rad_i_q[63:62]};
		trial_f = {2'b00, root_f_q, 2'b01};
		trial_i = {2'b00, root_i_q, 2'b01};
		rec_dig = dd_q[31:16];
		if (cnt_q == 7'd0) begin
			rec_dig = dd_q[63:48];
		end else if (cnt_q == 7'd1) begin
			rec_dig = dd_q[47:32];
		end
		resid   = dd_q[63:16] - qd_q;
		elapsed = $signed({1'b0, in_q.week_time_ms}) - $signed({1'b0, in_q.reset_time_ms});
		lim_w   = 33'(limit_q) * 33'(WINDOW);
		upd_sum = 65'(lam_q) + 65'(quot_q);
		nrm_v   = nrm_q[47:16];
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			conv_q      <= 20'd30000;
			minsat_q    <= 7'd8;
			limit_q     <= 23'd655360;
			lambda_q    <= 16'd64880;
			recip_q     <= 16'd655;
			thresh_q    <= 32'd65536;
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			ptr_q       <= '0;
			var_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			for (int k = 0; k < NumAxes; k++) begin
				sum_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_CONVERGENCE_TIME: conv_q   <= cfg_data[19:0];
					REG_MIN_SATELLITES:   minsat_q <= cfg_data[6:0];
					REG_DIVERGENCE_LIMIT: limit_q  <= cfg_data[22:0];
					REG_FORGETTING:       lambda_q <= cfg_data[15:0];
					REG_WINDOW_RECIP:     recip_q  <= cfg_data[15:0];
					REG_ALARM_THRESHOLD:  thresh_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						in_q    <= in_data;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					rd_valid_q <= valid_q[ptr_q];
					state_q    <= S_SUM;
				end
				S_SUM: begin
					for (int k = 0; k < NumAxes; k++) begin
						sum_q[k] <= sum_q[k] + SW'($signed(wr_data[k]))
							- (rd_valid_q ? SW'($signed(rd_q[k])) : SW'(0));
					end
					valid_q[ptr_q] <= 1'b1;
					ptr_q   <= (ptr_q == PW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
					acc_f_q <= '0;
					acc_i_q <= '0;
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					prod_q <= 64'(mag) * 64'(mag);
					if (cnt_q >= 7'd1 && cnt_q <= 7'd3) begin
						acc_f_q <= acc_f_q + prod_q;
					end else if (cnt_q >= 7'd4) begin
						acc_i_q <= acc_i_q + prod_q;
					end
					if (cnt_q == 7'd6) begin
						rad_f_q  <= acc_f_q;
						rad_i_q  <= acc_i_q + prod_q;
						rem_f_q  <= '0;
						rem_i_q  <= '0;
						root_f_q <= '0;
						root_i_q <= '0;
						cnt_q    <= '0;
						state_q  <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					rad_f_q <= {rad_f_q[61:0], 2'b00};
					rad_i_q <= {rad_i_q[61:0], 2'b00};
					if (remn_f >= trial_f) begin
						rem_f_q  <= 34'(remn_f - trial_f);
						root_f_q <= {root_f_q[30:0], 1'b1};
					end else begin
						rem_f_q  <= 34'(remn_f);
						root_f_q <= {root_f_q[30:0], 1'b0};
					end
					if (remn_i >= trial_i) begin
						rem_i_q  <= 34'(remn_i - trial_i);
						root_i_q <= {root_i_q[30:0], 1'b1};
					end else begin
						rem_i_q  <= 34'(remn_i);
						root_i_q <= {root_i_q[30:0], 1'b0};
					end
					if (cnt_q == 7'd31) begin
						cnt_q   <= '0;
						state_q <= S_DIFF;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIFF: begin
					d_q     <= (root_f_q >= root_i_q) ? root_f_q - root_i_q
						: root_i_q - root_f_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (elapsed > $signed({11'b0, conv_q}) && in_q.satellites_used >= minsat_q
						&& 33'(d_q) < lim_w) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_NRM;
					end
				end
				S_MUL: begin
					dd_q    <= 64'(d_q) * 64'(d_q);
					lam_q   <= 32'((48'(lambda_q) * 48'(var_q)) >> 16);
					rec_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_REC;
				end
				S_REC: begin
					rec_q <= {rec_q[79:0], 16'b0} + 96'(64'(rec_dig) * 64'(RECIP));
					if (cnt_q == 7'd2) begin
						cnt_q   <= '0;
						state_q <= S_QD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_QD: begin
					quot_q  <= rec_q[95:48];
					qd_q    <= 48'(64'(rec_q[95:48]) * 64'(WSQ));
					state_q <= S_ADJ;
				end
				S_ADJ: begin
					if (resid >= 48'(WSQ)) begin
						quot_q <= quot_q + 48'd1;
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					var_q   <= (upd_sum > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : upd_sum[31:0];
					state_q <= S_NRM;
				end
				S_NRM: begin
					nrm_q   <= 48'(var_q) * 48'(recip_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					out_q.normalized_variance <= nrm_v;
					out_q.alarm               <= nrm_v > thresh_q;
					out_valid_q               <= 1'b1;
					state_q                   <= S_IDLE;
				end
				default: ;
			endcase
		end
	end

endmodule
